### rtl/mspt_pkg.sv
// Shared types, widths, codes and Q16.16 arithmetic helpers for the
// matrix stack point transform core. No dependencies.
`default_nettype none

package mspt_pkg;

   // Defaults and fixed widths of the fields on the ports.
   localparam int STACK_DEPTH_DEF = 16;
   localparam int COORD_W         = 32;
   localparam int FRAC_BITS       = 16;
   localparam int MAT_DIM         = 4;
   localparam int MAT_ELEMS       = MAT_DIM * MAT_DIM;
   localparam int OP_W            = 3;
   localparam int STATUS_W        = 2;
   localparam int LEVEL_W         = 5;
   localparam int INDEX_W         = 2;
   localparam int REQ_FIELDS_W    = 2 * INDEX_W + 4 * COORD_W;
   localparam int REQ_DATA_W      = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W    = 3 * COORD_W + LEVEL_W;
   localparam int RSP_DATA_W      = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W       = RSP_DATA_W - RSP_FIELDS_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [MAT_ELEMS-1:0][COORD_W-1:0] mat_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam coord_type Q_ONE     = coord_type'(64'd1 << FRAC_BITS);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE     = 3'd0,
      OP_TRANSFORM = 3'd1,
      OP_TRANSLATE = 3'd2,
      OP_PUSH      = 3'd3,
      OP_POP       = 3'd4,
      OP_IDENTITY  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   // A clamped value and whether clamping took place.
   typedef struct packed {
      logic      sat;
      coord_type val;
   } sat_val_type;

   // Control that travels alongside each word through the pipeline.
   typedef struct packed {
      op_type               op;
      logic                 last;
      status_type           status;
      logic [LEVEL_W-1:0]   level;
      logic                 sat;
   } stage_ctl_type;

   // Q16.16 product, floored, clamped to the coordinate range.
   function automatic sat_val_type q_mul(input coord_type a, input coord_type b);
      logic signed [2*COORD_W-1:0] prod;
      logic                        fits;
      sat_val_type                 res;
      prod = a * b;
      fits = (&prod[2*COORD_W-1:FRAC_BITS+COORD_W-1]) ||
             !(|prod[2*COORD_W-1:FRAC_BITS+COORD_W-1]);
      res.sat = !fits;
      if (fits) begin
         res.val = prod[FRAC_BITS+COORD_W-1:FRAC_BITS];
      end else begin
         res.val = prod[2*COORD_W-1] ? COORD_MIN : COORD_MAX;
      end
      return res;
   endfunction

   // Saturating sum of two coordinates.
   function automatic sat_val_type sat_add(input coord_type a, input coord_type b);
      logic signed [COORD_W:0] sum;
      sat_val_type             res;
      sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      res.sat = (sum[COORD_W] != sum[COORD_W-1]);
      if (res.sat) begin
         res.val = sum[COORD_W] ? COORD_MIN : COORD_MAX;
      end else begin
         res.val = sum[COORD_W-1:0];
      end
      return res;
   endfunction

   function automatic mat_type identity_mat();
      mat_type m;
      for (int k = 0; k < MAT_ELEMS; k++) begin
         m[k] = (k == 0 || k == 5 || k == 10 || k == 15) ? Q_ONE : '0;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### rtl/matrix_stack_point_transform_core.sv
// Top level of the 4x4 homogeneous point transform with a matrix stack.
// Depends on mspt_pkg for widths, codes and the Q16.16 helpers.
`default_nettype none

// Channel | Dir | Words                               | Sideband
// req_    | in  | tdata: row, col, element, x, y, z   | tuser: operation, tlast: point end
// rsp_    | out | tdata: x, y, z, stack level         | tuser: status, tlast: point end
//
// Transforms, element writes, pushes and identity loads are accepted one word per
// cycle while the output does not stall; each result comes from the output register.
// A translate holds the input while its products update the matrix; a pop holds
// it while the stack memory is read.
// Synchronous reset loads the identity matrix, empties the stack and the pipeline;
// stack memory contents are not cleared and need no clearing pass.
// A stalled output fills the pipeline stage by stage before req_tready drops.

module matrix_stack_point_transform_core #(
   parameter int STACK_DEPTH = mspt_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // row_index[1:0], col_index[3:2], element_value[35:4], pos_x[67:36],
   // pos_y[99:68], pos_z[131:100], zero fill above
   input  wire logic [mspt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[2:0]
   input  wire logic [mspt_pkg::OP_W-1:0]        req_tuser,
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], stack_level[100:96], zero fill above
   output logic [mspt_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status[1:0]
   output logic [mspt_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LW     = mspt_pkg::LEVEL_W;

   // ------------------------------------------------------------------
   // Input word unpacking.
   // ------------------------------------------------------------------
   mspt_pkg::op_type    req_op;
   logic [1:0]          req_row;
   logic [1:0]          req_col;
   mspt_pkg::coord_type req_elem;
   mspt_pkg::coord_type pos [4];
   logic                req_fire;

   assign req_op   = mspt_pkg::op_type'(req_tuser);
   assign req_row  = req_tdata[1:0];
   assign req_col  = req_tdata[3:2];
   assign req_elem = req_tdata[35:4];
   assign pos[0]   = req_tdata[67:36];
   assign pos[1]   = req_tdata[99:68];
   assign pos[2]   = req_tdata[131:100];
   // The homogeneous column is added separately, so the products of this slot are never summed.
   assign pos[3]   = '0;
   assign req_fire = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // State: current matrix in flops, stack of saved matrices in a memory.
   // ------------------------------------------------------------------
   mspt_pkg::mat_type mat_ff, mat_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              pop_pending_ff, pop_pending_in;
   mspt_pkg::mat_type stack_mem [STACK_DEPTH];
   mspt_pkg::mat_type stack_rd_ff;

   logic stack_full, stack_empty;
   logic do_push, do_pop;
   logic [SP_W-1:0] sp_dec;

   assign stack_full  = (sp_ff == SP_W'(STACK_DEPTH));
   assign stack_empty = (sp_ff == '0);
   assign do_push     = req_fire && (req_op == mspt_pkg::OP_PUSH) && !stack_full;
   assign do_pop      = req_fire && (req_op == mspt_pkg::OP_POP) && !stack_empty;
   assign sp_dec      = sp_ff - SP_W'(1);

   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[sp_ff[ADDR_W-1:0]] <= mat_ff;
      end
      if (do_pop) begin
         stack_rd_ff <= stack_mem[sp_dec[ADDR_W-1:0]];
      end
   end

   always_comb begin
      sp_in = sp_ff;
      if (do_push) begin
         sp_in = sp_ff + SP_W'(1);
      end else if (do_pop) begin
         sp_in = sp_dec;
      end
   end

   // Stack level as it stands after the word, cut or extended to the field width.
   logic [SP_W+LW-1:0] level_ext;
   logic [LW-1:0]      level_new;
   assign level_ext = {{LW{1'b0}}, sp_in};
   assign level_new = level_ext[LW-1:0];

   // ------------------------------------------------------------------
   // Pipeline handshake: each stage loads when the stage ahead is free.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic load2, load3, load4;
   logic free1, free2, free3, free4;
   mspt_pkg::stage_ctl_type c1_ff, c2_ff, c3_ff, c4_ff;
   mspt_pkg::stage_ctl_type c1_in, c2_in, c3_in, c4_in;
   logic interlock;

   assign free4 = !v4_ff || rsp_tready;
   assign load4 = v3_ff && free4;
   assign free3 = !v3_ff || load4;
   assign load3 = v2_ff && free3;
   assign free2 = !v2_ff || load3;
   assign load2 = v1_ff && free2;
   assign free1 = !v1_ff || load2;

   // A translate in stage one still has to fold its products into the matrix,
   // and a pop waits for the memory read.
   assign interlock  = (v1_ff && (c1_ff.op == mspt_pkg::OP_TRANSLATE)) || pop_pending_ff;
   assign req_tready = free1 && !interlock;

   assign v1_in = req_fire || (v1_ff && !load2);
   assign v2_in = load2 || (v2_ff && !load3);
   assign v3_in = load3 || (v3_ff && !load4);
   assign v4_in = load4 || (v4_ff && !(v4_ff && rsp_tready));

   // ------------------------------------------------------------------
   // Stage one: twelve Q16.16 multipliers. A transform forms A[i][j]*p[j];
   // a translate forms p[i]*A[3][j].
   // ------------------------------------------------------------------
   mspt_pkg::coord_type s1_prod_ff [3][4];
   mspt_pkg::coord_type s1_prod_in [3][4];
   mspt_pkg::coord_type s1_m3_ff [3];
   logic                mul_sat;

   always_comb begin
      mspt_pkg::coord_type mul_a;
      mspt_pkg::coord_type mul_b;
      mspt_pkg::sat_val_type qm;
      mul_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (req_op == mspt_pkg::OP_TRANSLATE) begin
               mul_a = pos[i];
               mul_b = mat_ff[12 + j];
            end else begin
               mul_a = mat_ff[i * 4 + j];
               mul_b = pos[j];
            end
            qm = mspt_pkg::q_mul(mul_a, mul_b);
            s1_prod_in[i][j] = qm.val;
            mul_sat = mul_sat | qm.sat;
         end
      end
   end

   always_comb begin
      c1_in.op     = req_op;
      c1_in.last   = (req_op == mspt_pkg::OP_TRANSFORM) ? req_tlast : 1'b0;
      c1_in.level  = level_new;
      c1_in.status = mspt_pkg::ST_OK;
      if (req_op == mspt_pkg::OP_PUSH && stack_full) begin
         c1_in.status = mspt_pkg::ST_OVERFLOW;
      end else if (req_op == mspt_pkg::OP_POP && stack_empty) begin
         c1_in.status = mspt_pkg::ST_UNDERFLOW;
      end
      c1_in.sat = ((req_op == mspt_pkg::OP_TRANSFORM) ||
                   (req_op == mspt_pkg::OP_TRANSLATE)) && mul_sat;
   end

   // Translate fold: rows 0..2 take A[i][j] + p[i]*A[3][j], row 3 stays.
   mspt_pkg::mat_type nm;
   logic              nm_sat;
   always_comb begin
      mspt_pkg::sat_val_type sv;
      nm     = mat_ff;
      nm_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 4; j++) begin
            sv = mspt_pkg::sat_add(mat_ff[i * 4 + j], s1_prod_ff[i][j]);
            nm[i * 4 + j] = sv.val;
            nm_sat = nm_sat | sv.sat;
         end
      end
   end

   logic translate_apply;
   assign translate_apply = load2 && (c1_ff.op == mspt_pkg::OP_TRANSLATE);

   // ------------------------------------------------------------------
   // Stage two and three: the dot product sums, one saturating add per stage.
   // ------------------------------------------------------------------
   mspt_pkg::coord_type s2_acc_ff [3], s2_p2_ff [3], s2_m3_ff [3];
   mspt_pkg::coord_type s2_acc_in [3];
   mspt_pkg::coord_type s3_acc_ff [3], s3_m3_ff [3];
   mspt_pkg::coord_type s3_acc_in [3];
   mspt_pkg::coord_type s4_out_in [3];
   mspt_pkg::coord_type out_x_ff, out_y_ff, out_z_ff;
   logic add2_sat, add3_sat, add4_sat;
   logic c1_xform, c2_xform, c3_xform;

   assign c1_xform = (c1_ff.op == mspt_pkg::OP_TRANSFORM);
   assign c2_xform = (c2_ff.op == mspt_pkg::OP_TRANSFORM);
   assign c3_xform = (c3_ff.op == mspt_pkg::OP_TRANSFORM);

   always_comb begin
      mspt_pkg::sat_val_type sv;
      add2_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sv = mspt_pkg::sat_add(s1_prod_ff[i][0], s1_prod_ff[i][1]);
         s2_acc_in[i] = sv.val;
         add2_sat = add2_sat | sv.sat;
      end
      c2_in = c1_ff;
      c2_in.sat = c1_ff.sat || (c1_xform && add2_sat) ||
                  (!c1_xform && (c1_ff.op == mspt_pkg::OP_TRANSLATE) && nm_sat);
   end

   always_comb begin
      mspt_pkg::sat_val_type sv;
      add3_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sv = mspt_pkg::sat_add(s2_acc_ff[i], s2_p2_ff[i]);
         s3_acc_in[i] = sv.val;
         add3_sat = add3_sat | sv.sat;
      end
      c3_in = c2_ff;
      c3_in.sat = c2_ff.sat || (c2_xform && add3_sat);
   end

   // Stage four is the output register: translation column and final status.
   mspt_pkg::status_type status_final;
   always_comb begin
      mspt_pkg::sat_val_type sv;
      add4_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sv = mspt_pkg::sat_add(s3_acc_ff[i], s3_m3_ff[i]);
         s4_out_in[i] = c3_xform ? sv.val : '0;
         add4_sat = add4_sat | sv.sat;
      end
      status_final = c3_ff.status;
      if (c3_ff.status == mspt_pkg::ST_OK &&
          (c3_ff.sat || (c3_xform && add4_sat))) begin
         status_final = mspt_pkg::ST_SATURATED;
      end
      c4_in = c3_ff;
      c4_in.status = status_final;
   end

   // ------------------------------------------------------------------
   // Matrix update.
   // ------------------------------------------------------------------
   assign pop_pending_in = do_pop;

   always_comb begin
      mat_in = mat_ff;
      priority if (pop_pending_ff) begin
         mat_in = stack_rd_ff;
      end else if (translate_apply) begin
         mat_in = nm;
      end else if (req_fire && req_op == mspt_pkg::OP_WRITE) begin
         mat_in[{req_row, req_col}] = req_elem;
      end else if (req_fire && req_op == mspt_pkg::OP_IDENTITY) begin
         mat_in = mspt_pkg::identity_mat();
      end else begin
         mat_in = mat_ff;
      end
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff         <= mspt_pkg::identity_mat();
         sp_ff          <= '0;
         pop_pending_ff <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
      end else begin
         mat_ff         <= mat_in;
         sp_ff          <= sp_in;
         pop_pending_ff <= pop_pending_in;
         v1_ff          <= v1_in;
         v2_ff          <= v2_in;
         v3_ff          <= v3_in;
         v4_ff          <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_prod_ff <= s1_prod_in;
         for (int i = 0; i < 3; i++) begin
            s1_m3_ff[i] <= mat_ff[i * 4 + 3];
         end
         c1_ff <= c1_in;
      end
      if (load2) begin
         s2_acc_ff <= s2_acc_in;
         for (int i = 0; i < 3; i++) begin
            s2_p2_ff[i] <= s1_prod_ff[i][2];
         end
         s2_m3_ff <= s1_m3_ff;
         c2_ff    <= c2_in;
      end
      if (load3) begin
         s3_acc_ff <= s3_acc_in;
         s3_m3_ff  <= s2_m3_ff;
         c3_ff     <= c3_in;
      end
      if (load4) begin
         out_x_ff <= s4_out_in[0];
         out_y_ff <= s4_out_in[1];
         out_z_ff <= s4_out_in[2];
         c4_ff    <= c4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {{mspt_pkg::RSP_PAD_W{1'b0}}, c4_ff.level, out_z_ff, out_y_ff, out_x_ff};
   assign rsp_tuser  = c4_ff.status;
   assign rsp_tlast  = c4_ff.last;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_pop_interlock : assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |-> !req_fire)
      else $error("word accepted while a pop read was pending");

   a_translate_interlock : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && c1_ff.op == mspt_pkg::OP_TRANSLATE) |-> !req_fire)
      else $error("word accepted before translate updated the matrix");

   a_sp_bound : assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      do_push |=> (sp_ff == $past(sp_ff) + SP_W'(1)))
      else $error("push did not advance the stack pointer");

   a_pop_loads : assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |=> (mat_ff == $past(stack_rd_ff)))
      else $error("pop did not load the saved matrix");

endmodule

`default_nettype wire

### tb/tb_matrix_stack_point_transform_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the matrix stack point transform core.
// Depends on mspt_pkg and the core RTL; it predicts every response word itself.

module tb_matrix_stack_point_transform_core;

   localparam int CLK_PERIOD = 20;
   localparam int RESET_CYCLES = 8;
   // Run limit in ns, far above the slowest legal run of this stimulus.
   localparam int RUN_LIMIT_NS = 10_000_000;
   localparam int RANDOM_WORDS = 380;
   localparam int HOLD_OFF_CYCLES = 200;

   // Operation codes that the core does not define; they must be answered with zeros.
   localparam logic [mspt_pkg::OP_W-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [mspt_pkg::OP_W-1:0] OP_RESERVED_B = 3'd7;

   // Bit positions of the fields inside req_tdata and rsp_tdata.
   localparam int COL_LSB   = mspt_pkg::INDEX_W;
   localparam int ELEM_LSB  = 2 * mspt_pkg::INDEX_W;
   localparam int X_LSB     = ELEM_LSB + mspt_pkg::COORD_W;
   localparam int Y_LSB     = X_LSB + mspt_pkg::COORD_W;
   localparam int Z_LSB     = Y_LSB + mspt_pkg::COORD_W;
   localparam int OUT_Y_LSB = mspt_pkg::COORD_W;
   localparam int OUT_Z_LSB = 2 * mspt_pkg::COORD_W;
   localparam int LEVEL_LSB = 3 * mspt_pkg::COORD_W;

   // One predicted response word.
   typedef struct packed {
      mspt_pkg::coord_type          x;
      mspt_pkg::coord_type          y;
      mspt_pkg::coord_type          z;
      logic                         last;
      mspt_pkg::status_type         status;
      logic [mspt_pkg::LEVEL_W-1:0] level;
   } point_result_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [mspt_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic [mspt_pkg::OP_W-1:0]         req_tuser;
   logic                              req_tlast;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [mspt_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [mspt_pkg::STATUS_W-1:0]     rsp_tuser;
   logic                              rsp_tlast;

   // Shadow copy of the core's matrix state, updated as each word is accepted.
   mspt_pkg::coord_type model_mat [mspt_pkg::MAT_ELEMS];
   mspt_pkg::coord_type saved_mats [mspt_pkg::STACK_DEPTH_DEF][mspt_pkg::MAT_ELEMS];
   int        saved_count;
   bit        arith_sat;

   // Responses still owed by the core, oldest first.
   point_result_type pending_results [$];

   int error_count = 0;
   int words_sent = 0;
   bit sender_idles = 1'b1;
   int hold_off_cycles = 0;
   bit hold_active = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   matrix_stack_point_transform_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------------------
   // Q16.16 arithmetic of the predictor. Any clamp raises arith_sat.
   // ------------------------------------------------------------------

   function automatic mspt_pkg::coord_type clamp_coord(input longint v);
      if (v > longint'(mspt_pkg::COORD_MAX)) begin
         arith_sat = 1'b1;
         return mspt_pkg::COORD_MAX;
      end
      if (v < longint'(mspt_pkg::COORD_MIN)) begin
         arith_sat = 1'b1;
         return mspt_pkg::COORD_MIN;
      end
      return mspt_pkg::coord_type'(v);
   endfunction

   // The full product fits in 64 bits, and an arithmetic shift floors it.
   function automatic mspt_pkg::coord_type fixed_product(input mspt_pkg::coord_type a,
                                                         input mspt_pkg::coord_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp_coord(p >>> mspt_pkg::FRAC_BITS);
   endfunction

   function automatic mspt_pkg::coord_type fixed_sum(input mspt_pkg::coord_type a,
                                                     input mspt_pkg::coord_type b);
      return clamp_coord(longint'(a) + longint'(b));
   endfunction

   task automatic load_identity_model();
      for (int k = 0; k < mspt_pkg::MAT_ELEMS; k++) begin
         model_mat[k] = (k % (mspt_pkg::MAT_DIM + 1) == 0) ? mspt_pkg::Q_ONE :
                                                             mspt_pkg::coord_type'(0);
      end
   endtask

   // Applies one accepted word to the shadow state and queues the response it owes.
   task automatic predict_response(input logic [mspt_pkg::OP_W-1:0] op,
                                   input logic [mspt_pkg::INDEX_W-1:0] row,
                                   input logic [mspt_pkg::INDEX_W-1:0] col,
                                   input mspt_pkg::coord_type elem,
                                   input mspt_pkg::coord_type x,
                                   input mspt_pkg::coord_type y,
                                   input mspt_pkg::coord_type z,
                                   input logic last);
      point_result_type    res;
      mspt_pkg::coord_type pt [3];
      mspt_pkg::coord_type out_pt [3];
      mspt_pkg::coord_type next_mat [mspt_pkg::MAT_ELEMS];
      mspt_pkg::coord_type acc;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      out_pt[0] = '0;
      out_pt[1] = '0;
      out_pt[2] = '0;
      res.last = 1'b0;
      res.status = mspt_pkg::ST_OK;
      arith_sat = 1'b0;
      case (op)
         mspt_pkg::OP_WRITE: begin
            model_mat[row * mspt_pkg::MAT_DIM + col] = elem;
         end
         mspt_pkg::OP_TRANSFORM: begin
            // Each row adds its terms in column order, clamping after every add,
            // and the translation column comes last.
            for (int i = 0; i < 3; i++) begin
               acc = '0;
               for (int j = 0; j < 3; j++) begin
                  acc = fixed_sum(acc,
                                  fixed_product(model_mat[i * mspt_pkg::MAT_DIM + j], pt[j]));
               end
               out_pt[i] = fixed_sum(acc, model_mat[i * mspt_pkg::MAT_DIM + 3]);
            end
            res.last = last;
         end
         mspt_pkg::OP_TRANSLATE: begin
            // A = T * A: row i gains pos[i] times row 3; row 3 itself stays.
            next_mat = model_mat;
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < mspt_pkg::MAT_DIM; j++) begin
                  next_mat[i * mspt_pkg::MAT_DIM + j] =
                     fixed_sum(model_mat[i * mspt_pkg::MAT_DIM + j],
                               fixed_product(pt[i], model_mat[3 * mspt_pkg::MAT_DIM + j]));
               end
            end
            model_mat = next_mat;
         end
         mspt_pkg::OP_PUSH: begin
            if (saved_count >= mspt_pkg::STACK_DEPTH_DEF) begin
               res.status = mspt_pkg::ST_OVERFLOW;
            end else begin
               saved_mats[saved_count] = model_mat;
               saved_count++;
            end
         end
         mspt_pkg::OP_POP: begin
            if (saved_count == 0) begin
               res.status = mspt_pkg::ST_UNDERFLOW;
            end else begin
               saved_count--;
               model_mat = saved_mats[saved_count];
            end
         end
         mspt_pkg::OP_IDENTITY: begin
            load_identity_model();
         end
         default: begin
         end
      endcase
      if (res.status == mspt_pkg::ST_OK && arith_sat) begin
         res.status = mspt_pkg::ST_SATURATED;
      end
      res.x = out_pt[0];
      res.y = out_pt[1];
      res.z = out_pt[2];
      res.level = saved_count[mspt_pkg::LEVEL_W-1:0];
      pending_results.push_back(res);
   endtask

   // ------------------------------------------------------------------
   // Sender. A random gap may come first; then the word is held until the
   // core takes it. Valid is left high after a handshake so that back to back
   // words never see a low and a high assignment within one time step.
   // ------------------------------------------------------------------

   task automatic send_word(input logic [mspt_pkg::OP_W-1:0] op,
                            input logic [mspt_pkg::INDEX_W-1:0] row,
                            input logic [mspt_pkg::INDEX_W-1:0] col,
                            input mspt_pkg::coord_type elem,
                            input mspt_pkg::coord_type x,
                            input mspt_pkg::coord_type y,
                            input mspt_pkg::coord_type z,
                            input logic last);
      logic [mspt_pkg::REQ_DATA_W-1:0] word;
      int                              gap;
      int                              r;
      word = '0;
      word[0 +: mspt_pkg::INDEX_W] = row;
      word[COL_LSB +: mspt_pkg::INDEX_W] = col;
      word[ELEM_LSB +: mspt_pkg::COORD_W] = elem;
      word[X_LSB +: mspt_pkg::COORD_W] = x;
      word[Y_LSB +: mspt_pkg::COORD_W] = y;
      word[Z_LSB +: mspt_pkg::COORD_W] = z;
      gap = 0;
      if (sender_idles) begin
         r = $urandom_range(0, 99);
         if (r >= 55) begin
            gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= op;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_response(op, row, col, elem, x, y, z, last);
      words_sent++;
   endtask

   // Small coordinates half the time, as real geometry has, with extremes and raw words mixed in.
   function automatic mspt_pkg::coord_type random_q16();
      case ($urandom_range(0, 9))
         0: return mspt_pkg::COORD_MAX;
         1: return mspt_pkg::COORD_MIN;
         2: return '0;
         3, 4: return mspt_pkg::coord_type'($urandom);
         default: return mspt_pkg::coord_type'($urandom_range(0, 32'h0010_0000)) -
                         32'sh0008_0000;
      endcase
   endfunction

   task automatic send_random(input logic [mspt_pkg::OP_W-1:0] op, input logic last);
      send_word(op, mspt_pkg::INDEX_W'($urandom_range(0, 3)),
                mspt_pkg::INDEX_W'($urandom_range(0, 3)),
                random_q16(), random_q16(), random_q16(), random_q16(), last);
   endtask

   // The sender stops offering and waits until every owed response has come back.
   task automatic pause_sender_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Receiver. Random stalls of mixed length, long ready runs, and on request
   // one long hold-off counted here so the core backs up into its input.
   // ------------------------------------------------------------------

   initial begin
      int n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_active = 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            hold_active = 1'b0;
         end else begin
            n = $urandom_range(0, 99);
            if (n < 25) begin
               rsp_tready <= 1'b0;
               repeat ((n < 22) ? $urandom_range(1, 3) : $urandom_range(10, 40))
                  @(posedge clock);
            end else begin
               rsp_tready <= 1'b1;
               repeat ((n > 90) ? $urandom_range(20, 60) : $urandom_range(1, 6))
                  @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every word taken from the core is compared field by
   // field with the oldest prediction.
   // ------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_error($sformatf("%s is %0d, predicted %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      point_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_error("response word with no prediction pending");
         end else begin
            want = pending_results.pop_front();
            check_field("out_x", mspt_pkg::coord_type'(rsp_tdata[0 +: mspt_pkg::COORD_W]),
                        want.x);
            check_field("out_y",
                        mspt_pkg::coord_type'(rsp_tdata[OUT_Y_LSB +: mspt_pkg::COORD_W]),
                        want.y);
            check_field("out_z",
                        mspt_pkg::coord_type'(rsp_tdata[OUT_Z_LSB +: mspt_pkg::COORD_W]),
                        want.z);
            check_field("stack_level", rsp_tdata[LEVEL_LSB +: mspt_pkg::LEVEL_W], want.level);
            check_field("status", rsp_tuser, want.status);
            check_field("out_last", rsp_tlast, want.last);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // The reset matrix is the identity, so points come back unchanged.
   task automatic test_identity_points();
      send_word(mspt_pkg::OP_TRANSFORM, 2'd0, 2'd0, '0, mspt_pkg::COORD_MAX,
                mspt_pkg::COORD_MIN, '0, 1'b1);
      send_word(mspt_pkg::OP_TRANSFORM, 2'd3, 2'd3, mspt_pkg::COORD_MIN, -mspt_pkg::Q_ONE,
                mspt_pkg::Q_ONE, mspt_pkg::COORD_MIN, 1'b0);
   endtask

   // Element writes at the corners of the value range, a saturating transform,
   // then the identity load restores the reset matrix.
   task automatic test_element_writes();
      send_word(mspt_pkg::OP_WRITE, 2'd0, 2'd0, mspt_pkg::COORD_MAX, '0, '0, '0, 1'b1);
      send_word(mspt_pkg::OP_WRITE, 2'd1, 2'd3, mspt_pkg::COORD_MIN, mspt_pkg::COORD_MAX,
                mspt_pkg::COORD_MAX, mspt_pkg::COORD_MAX, 1'b0);
      send_word(mspt_pkg::OP_WRITE, 2'd2, 2'd1, -mspt_pkg::Q_ONE, '0, '0, '0, 1'b0);
      send_word(mspt_pkg::OP_WRITE, 2'd3, 2'd2, 32'sh0001_8000, '0, '0, '0, 1'b0);
      send_word(mspt_pkg::OP_TRANSFORM, 2'd0, 2'd0, '0, mspt_pkg::Q_ONE, mspt_pkg::Q_ONE,
                mspt_pkg::Q_ONE, 1'b1);
      send_word(mspt_pkg::OP_TRANSFORM, 2'd0, 2'd0, '0, 2 * mspt_pkg::Q_ONE,
                -mspt_pkg::Q_ONE, mspt_pkg::Q_ONE / 2, 1'b0);
      send_word(mspt_pkg::OP_IDENTITY, 2'd0, 2'd0, '0, '0, '0, '0, 1'b1);
      send_word(mspt_pkg::OP_TRANSFORM, 2'd0, 2'd0, '0, 32'sh0003_0000, -32'sh0000_8000,
                '0, 1'b1);
   endtask

   // Translation composes through row 3; a huge row 3 entry saturates the compose.
   task automatic test_translate_compose();
      send_word(mspt_pkg::OP_WRITE, 2'd3, 2'd0, mspt_pkg::COORD_MAX, '0, '0, '0, 1'b0);
      send_word(mspt_pkg::OP_TRANSLATE, 2'd0, 2'd0, '0, mspt_pkg::COORD_MAX,
                mspt_pkg::Q_ONE, mspt_pkg::COORD_MIN, 1'b1);
      send_random(mspt_pkg::OP_TRANSFORM, 1'b1);
      send_word(mspt_pkg::OP_IDENTITY, 2'd0, 2'd0, '0, '0, '0, '0, 1'b0);
      send_word(mspt_pkg::OP_TRANSLATE, 2'd0, 2'd0, '0, 32'sh0003_0000, -32'sh0002_8000,
                32'sh0000_4000, 1'b0);
      send_word(mspt_pkg::OP_TRANSFORM, 2'd0, 2'd0, '0, mspt_pkg::Q_ONE, -mspt_pkg::Q_ONE,
                32'sh0001_0001, 1'b1);
   endtask

   // Pop from an empty stack, fill it to the top with distinct matrices, push once
   // too often, then unwind it, checking each restored matrix with a transform.
   task automatic test_stack_limits();
      pause_sender_until_drained();
      while (saved_count > 0) send_random(mspt_pkg::OP_POP, 1'b0);
      send_random(mspt_pkg::OP_POP, 1'b1);
      while (saved_count < mspt_pkg::STACK_DEPTH_DEF) begin
         send_random(mspt_pkg::OP_WRITE, 1'b0);
         send_random(mspt_pkg::OP_PUSH, 1'b0);
      end
      send_random(mspt_pkg::OP_PUSH, 1'b1);
      send_random(mspt_pkg::OP_TRANSFORM, 1'b1);
      while (saved_count > 0) begin
         send_random(mspt_pkg::OP_POP, 1'b0);
         send_random(mspt_pkg::OP_TRANSFORM, 1'b0);
      end
      send_random(mspt_pkg::OP_POP, 1'b0);
   endtask

   // Undefined operation codes must change nothing and answer with zeros.
   task automatic test_reserved_codes();
      send_random(OP_RESERVED_A, 1'b1);
      send_random(OP_RESERVED_B, 1'b1);
      send_random(mspt_pkg::OP_TRANSFORM, 1'b0);
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the
   // input while words keep coming without gaps.
   task automatic test_output_backpressure();
      pause_sender_until_drained();
      hold_off_cycles = HOLD_OFF_CYCLES;
      while (!hold_active) @(posedge clock);
      sender_idles = 1'b0;
      for (int k = 0; k < 40; k++) send_random(mspt_pkg::OP_TRANSFORM, k % 8 == 7);
      sender_idles = 1'b1;
      pause_sender_until_drained();
   endtask

   // Random objects: push, set up the matrix, stream its points with the end
   // mark on the final one, pop. Random noise words are mixed in between.
   task automatic test_random_stream();
      int goal;
      int count;
      int r;
      goal = words_sent + RANDOM_WORDS;
      while (words_sent < goal) begin
         sender_idles = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 99) < 75) begin
            send_random(mspt_pkg::OP_PUSH, 1'($urandom_range(0, 1)));
            count = $urandom_range(1, 3);
            for (int k = 0; k < count; k++) begin
               r = $urandom_range(0, 9);
               if (r < 6) begin
                  send_random(mspt_pkg::OP_WRITE, 1'($urandom_range(0, 1)));
               end else if (r < 9) begin
                  send_random(mspt_pkg::OP_TRANSLATE, 1'($urandom_range(0, 1)));
               end else begin
                  send_random(mspt_pkg::OP_IDENTITY, 1'($urandom_range(0, 1)));
               end
            end
            count = $urandom_range(1, 8);
            for (int k = 0; k < count; k++) begin
               send_random(mspt_pkg::OP_TRANSFORM, k == count - 1);
            end
            send_random(mspt_pkg::OP_POP, 1'($urandom_range(0, 1)));
         end else begin
            count = $urandom_range(1, 4);
            for (int k = 0; k < count; k++) begin
               send_random(mspt_pkg::OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
         end
      end
      sender_idles = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      req_tlast <= 1'b0;
      load_identity_model();
      saved_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_identity_points();
      test_element_writes();
      test_translate_compose();
      test_reserved_codes();
      test_stack_limits();
      test_output_backpressure();
      test_random_stream();

      // Let the last responses arrive, then keep watching for strays before the verdict.
      pause_sender_until_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("ERROR: run limit reached with %0d responses pending", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
rtl/mspt_pkg.sv
rtl/matrix_stack_point_transform_core.sv
tb/tb_matrix_stack_point_transform_core.sv
